/* hdl/ust_pkg.sv */
// ----------------------------------------------------------------------------
// ust_pkg
// Shared sizes and types of the unique set table.
// ----------------------------------------------------------------------------
package ust_pkg;

  localparam int CAPACITY  = 16;
  localparam int VALUE_W   = 32;
  localparam int OP_W      = 2;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int MCOUNT_W  = 5;
  localparam int IN_DATA_W  = ((OP_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((1 + MCOUNT_W + 1 + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [VALUE_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

  typedef struct packed {
    logic             valid;
    logic             ok;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

/* hdl/ust_ram.sv */
// ----------------------------------------------------------------------------
// ust_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ust_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/ust_ctrl.sv */
// ----------------------------------------------------------------------------
// ust_ctrl
// Sequencer: scans the store for a value, appends or compacts, keeps count.
// ----------------------------------------------------------------------------
module ust_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ust_pkg::OP_W-1:0]     in_op,
  input  logic [ust_pkg::VALUE_W-1:0]  in_value,
  input  logic                         out_free,
  output ust_pkg::result_t             res,
  output ust_pkg::ram_req_t            ram_req,
  input  logic [ust_pkg::VALUE_W-1:0]  ram_rdata
);
  import ust_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t             state, state_next;
  logic [OP_W-1:0]    op;
  logic [VALUE_W-1:0] value;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   rd_idx, rd_idx_next;
  logic               pend, pend_next;
  logic [IDX_W-1:0]   pend_idx, pend_idx_next;
  logic               ok, ok_next;
  logic               hit;
  logic               more;

  assign in_ready = (state == S_IDLE);
  assign hit      = pend && (ram_rdata == value);
  assign more     = (rd_idx < count);

  assign res.valid = (state == S_DONE) && out_free;
  assign res.ok    = ok;
  assign res.count = count;

  always_comb begin
    state_next    = state;
    count_next    = count;
    rd_idx_next   = rd_idx;
    pend_next     = pend;
    pend_idx_next = pend_idx;
    ok_next       = ok;
    ram_req       = '0;
    ram_req.wdata = value;
    ram_req.raddr = rd_idx[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          rd_idx_next = '0;
          pend_next   = 1'b0;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || (!pend && !more)) begin
          state_next = S_DONE;
          ok_next    = 1'b0;
          pend_next  = 1'b0;
          case (op)
            OP_INSERT: begin
              if (!hit && (count < CNT_W'(CAPACITY))) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = count[IDX_W-1:0];
                count_next    = count + CNT_W'(1);
                ok_next       = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                ok_next     = 1'b1;
                rd_idx_next = CNT_W'(pend_idx) + CNT_W'(1);
                state_next  = S_SHIFT;
              end
            end
            OP_QUERY: ok_next = hit;
            default:  ok_next = 1'b0;
          endcase
        end else begin
          ram_req.re    = more;
          rd_idx_next   = more ? rd_idx + CNT_W'(1) : rd_idx;
          pend_next     = more;
          pend_idx_next = rd_idx[IDX_W-1:0];
        end
      end
      S_SHIFT: begin
        if (pend) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pend_idx - IDX_W'(1);
          ram_req.wdata = ram_rdata;
        end
        ram_req.re    = more;
        rd_idx_next   = more ? rd_idx + CNT_W'(1) : rd_idx;
        pend_next     = more;
        pend_idx_next = rd_idx[IDX_W-1:0];
        if (!pend && !more) begin
          count_next = count - CNT_W'(1);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
    rd_idx   <= rd_idx_next;
    pend_idx <= pend_idx_next;
    ok       <= ok_next;
    if (in_valid && in_ready) begin
      op    <= in_op;
      value <= in_value;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("member count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !ram_req.we)
    else $error("store written outside an operation");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("read and write of the same entry");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_SCAN && state != S_SHIFT) |=> $stable(count))
    else $error("count changed while idle");
`endif

endmodule

/* hdl/unique_set_table.sv */
// ----------------------------------------------------------------------------
// unique_set_table
// Bounded set of distinct signed 32-bit values kept in insertion order.
// ----------------------------------------------------------------------------
// Each transaction inserts, removes or looks up one value and returns one
// result with success, the new member count and an empty flag. The members
// sit in a 16-entry RAM with a registered read; the sequencer scans it one
// entry per cycle up to the match or the last member. An insert writes its
// append as the scan ends; a remove of a member then moves the later entries
// down one place. One transaction is worked on at a time; the result
// register lets the next transaction start while a result waits.
module unique_set_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [1:0] operation, [33:2] element_value, rest zero
  input  logic [ust_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] success, [5:1] member_count, [6] is_empty, rest zero
  output logic [ust_pkg::OUT_DATA_W-1:0] m_tdata
);
  import ust_pkg::*;

  ram_req_t           ram_req;
  result_t            res;
  logic [VALUE_W-1:0] ram_rdata;
  logic               out_free;

  assign out_free = !m_tvalid || m_tready;

  ust_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tdata[OP_W-1:0]),
    .in_value  (s_tdata[OP_W+VALUE_W-1:OP_W]),
    .out_free  (out_free),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  ust_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res.valid) begin
      m_tdata <= OUT_DATA_W'({(res.count == '0), MCOUNT_W'(res.count), res.ok});
    end
  end

endmodule

/* test/set_table_monitor.sv */
// ----------------------------------------------------------------------------
// set_table_monitor
// Watches both stream channels of the unique set table and checks each reply.
// ----------------------------------------------------------------------------
// Every transaction accepted on the slave side is applied to a private model of
// the set: an ordered array of members and a member count. The resulting reply
// (success, count, empty) is queued. Every reply accepted on the master side is
// compared field by field with the oldest queued reply.
module set_table_monitor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // [1:0] operation, [33:2] element_value, rest zero
  input  logic [ust_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] success, [5:1] member_count, [6] is_empty, rest zero
  input  logic [ust_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                             mismatches,
  output int                             outstanding,
  output int                             ops_seen,
  output int                             replies_seen,
  output int                             full_hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import ust_pkg::*;

  typedef struct packed {
    logic       empty;
    logic [4:0] count;
    logic       success;
  } set_reply_t;

  logic [VALUE_W-1:0] members [CAPACITY];
  int                 held;
  set_reply_t         replies_due [$];
  set_reply_t         want;
  set_reply_t         got;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    ops_seen     = 0;
    replies_seen = 0;
    full_hits    = 0;
    held         = 0;
  end

  task automatic flag_error(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic set_reply_t apply_set_op(input op_t op, input logic [VALUE_W-1:0] v);
    set_reply_t r;
    int         pos;
    r.success = 1'b0;
    pos = held;
    for (int i = held - 1; i >= 0; i--) begin
      if (members[i] == v) pos = i;
    end
    case (op)
      OP_INSERT: begin
        if (held == CAPACITY) full_hits++;
        if (held < CAPACITY && pos == held) begin
          members[held] = v;
          held++;
          r.success = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos < held) begin
          for (int j = pos; j < held - 1; j++) members[j] = members[j + 1];
          held--;
          r.success = 1'b1;
        end
      end
      OP_QUERY: begin
        r.success = (pos < held);
      end
      default: begin
      end
    endcase
    r.count = held[4:0];
    r.empty = (held == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held = 0;
      replies_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        replies_seen++;
        got = m_tdata[6:0];
        if (replies_due.size() == 0) begin
          flag_error($sformatf("reply %0d with nothing outstanding", replies_seen));
        end else begin
          want = replies_due.pop_front();
          if (got.success !== want.success)
            flag_error($sformatf("reply %0d success got %b want %b",
                                 replies_seen, got.success, want.success));
          if (got.count !== want.count)
            flag_error($sformatf("reply %0d member_count got %0d want %0d",
                                 replies_seen, got.count, want.count));
          if (got.empty !== want.empty)
            flag_error($sformatf("reply %0d is_empty got %b want %b",
                                 replies_seen, got.empty, want.empty));
        end
      end
      if (s_tvalid && s_tready) begin
        ops_seen++;
        replies_due.push_back(apply_set_op(op_t'(s_tdata[OP_W-1:0]),
                                           s_tdata[OP_W +: VALUE_W]));
      end
    end
    outstanding = replies_due.size();
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the unique set table.
// ----------------------------------------------------------------------------
// A directed run covers the empty and full set, extreme values, duplicates,
// removal from the middle and from the end, and the unused operation code.
// Random runs then draw values mostly from a small pool so the set fills,
// empties and sees repeated values, under four sender/receiver pacing modes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ust_pkg::*;

  localparam int POOL_N      = 24;
  localparam int STALL_LIMIT = 4000;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tready = 1'b0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [OUT_DATA_W-1:0] m_tdata;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;
  int mismatches;
  int outstanding;
  int ops_seen;
  int replies_seen;
  int full_hits;

  logic [VALUE_W-1:0] pool [POOL_N];

  unique_set_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  set_table_monitor mon (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .ops_seen     (ops_seen),
    .replies_seen (replies_seen),
    .full_hits    (full_hits)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send(input op_t op, input logic [VALUE_W-1:0] v);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[OP_W-1:0] = op;
    word[OP_W +: VALUE_W] = v;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic run_mix(input int sidle, input int stall, input int n);
    int                 r;
    op_t                op;
    logic [VALUE_W-1:0] v;
    send_idle_pct = sidle;
    stall_pct     = stall;
    for (int k = 0; k < POOL_N; k++) pool[k] = $urandom;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 40)      op = OP_INSERT;
      else if (r < 70) op = OP_REMOVE;
      else if (r < 95) op = OP_QUERY;
      else             op = OP_NONE;
      if ($urandom_range(99) < 85) v = pool[$urandom_range(POOL_N - 1)];
      else                         v = $urandom;
      send(op, v);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(OP_QUERY,  32'h8000_0000);
    send(OP_REMOVE, 32'h0000_0000);
    send(OP_NONE,   32'h7fff_ffff);
    send(OP_INSERT, 32'h0000_0000);
    send(OP_INSERT, 32'h8000_0000);
    send(OP_INSERT, 32'h7fff_ffff);
    send(OP_INSERT, 32'hffff_ffff);
    send(OP_INSERT, 32'h7fff_ffff);
    send(OP_QUERY,  32'h8000_0000);
    send(OP_QUERY,  32'h0000_0001);
    send(OP_REMOVE, 32'h8000_0000);
    send(OP_REMOVE, 32'hffff_ffff);
    send(OP_REMOVE, 32'h8000_0000);
    send(OP_NONE,   32'h0000_0000);
    for (int i = 0; i < 14; i++) send(OP_INSERT, 32'h1000_0000 + i);
    send(OP_INSERT, 32'h5a5a_a5a5);
    send(OP_NONE,   32'h5a5a_a5a5);
    send(OP_REMOVE, 32'h1000_000d);

    run_mix(0,  0,  215);
    run_mix(80, 0,  210);
    run_mix(0,  80, 210);
    run_mix(30, 30, 215);

    s_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d set operations and %0d replies over four pacing modes",
             ops_seen, replies_seen);
    $display("inserts attempted on a full set: %0d, mismatches: %0d",
             full_hits, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
